// ===== rtl/ovs_pkg.sv =====
package ovs_pkg;

   localparam int ACC_BITS       = 28;
   localparam int COUNT_BITS     = 17;
   localparam int SLOT_BITS      = 4;
   localparam int VALUE_BITS     = 16;
   localparam int CHAN_BITS      = 5;
   localparam int LIST_BITS      = 40;
   localparam int NUM_CH_BITS    = 5;
   localparam int OS_BITS        = 5;
   localparam int EXTRA_BITS     = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 40;
   localparam int OS_LIMIT       = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_NUM_CHANNELS      = 3'd0,
      REG_OVERSAMPLE_LOG2   = 3'd1,
      REG_EXTRA_BITS        = 3'd2,
      REG_CHANNEL_LIST_LOW  = 3'd3,
      REG_CHANNEL_LIST_HIGH = 3'd4
   } ovs_reg_type;

   typedef struct packed {
      logic [NUM_CH_BITS-1:0] num_channels;
      logic [OS_BITS-1:0]     oversample_log2;
      logic [EXTRA_BITS-1:0]  extra_bits;
      logic [LIST_BITS-1:0]   channel_list_low;
      logic [LIST_BITS-1:0]   channel_list_high;
   } ovs_cfg_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  slot;
      logic [VALUE_BITS-1:0] value;
      logic [CHAN_BITS-1:0]  next_channel;
      logic                  scan_complete;
   } ovs_result_type;

endpackage

// ===== rtl/ovs_if.sv =====
interface ovs_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface ovs_rsp_if;
   import ovs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SLOT_BITS-1:0]  slot;
   logic [VALUE_BITS-1:0] value;
   logic [CHAN_BITS-1:0]  next_channel;
   logic                  scan_complete;

   modport source (output valid, output slot, output value, output next_channel,
                   output scan_complete, input ready);
   modport sink (input valid, input slot, input value, input next_channel,
                 input scan_complete, output ready);
endinterface

// ===== rtl/ovs_csr.sv =====
module ovs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ovs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ovs_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   output ovs_pkg::ovs_cfg_type                cfg
);
   import ovs_pkg::*;

   ovs_cfg_type cfg_ff;
   ovs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (ovs_reg_type'(csr_index))
            REG_NUM_CHANNELS:      cfg_in.num_channels      = csr_wr_data[NUM_CH_BITS-1:0];
            REG_OVERSAMPLE_LOG2:   cfg_in.oversample_log2   = csr_wr_data[OS_BITS-1:0];
            REG_EXTRA_BITS:        cfg_in.extra_bits        = csr_wr_data[EXTRA_BITS-1:0];
            REG_CHANNEL_LIST_LOW:  cfg_in.channel_list_low  = csr_wr_data[LIST_BITS-1:0];
            REG_CHANNEL_LIST_HIGH: cfg_in.channel_list_high = csr_wr_data[LIST_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels      <= NUM_CH_BITS'(1);
         cfg_ff.oversample_log2   <= OS_BITS'(1);
         cfg_ff.extra_bits        <= '0;
         cfg_ff.channel_list_low  <= '0;
         cfg_ff.channel_list_high <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ovs_core.sv =====
module ovs_core #(
   parameter int MAX_SLOTS   = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ovs_pkg::ovs_cfg_type             cfg,
   input  logic                             step,
   input  logic [SAMPLE_BITS-1:0]           sample,
   output logic                             hit,
   output ovs_pkg::ovs_result_type          result,
   output logic [ovs_pkg::SLOT_BITS-1:0]    slot_index
);
   import ovs_pkg::*;

   logic [ACC_BITS-1:0]      acc_ff, acc_in, acc_sum;
   logic [COUNT_BITS-1:0]    count_ff, count_in, count_sum, target;
   logic [SLOT_BITS-1:0]     slot_ff, slot_in, slot_next;
   logic [OS_BITS-1:0]       os, shift;
   logic [NUM_CH_BITS-1:0]   n, slot_inc;
   logic                     wrap;
   logic [2*LIST_BITS-1:0]   list;

   always_comb begin
      acc_sum   = acc_ff + ACC_BITS'(sample);
      count_sum = count_ff + COUNT_BITS'(1);

      os     = (cfg.oversample_log2 > OS_BITS'(OS_LIMIT)) ? OS_BITS'(OS_LIMIT)
                                                          : cfg.oversample_log2;
      target = COUNT_BITS'(1) << os;
      hit    = (count_sum == target);

      shift = (OS_BITS'(cfg.extra_bits) >= os) ? '0 : os - OS_BITS'(cfg.extra_bits);

      // clamp the slot count into 1..MAX_SLOTS
      n = cfg.num_channels;
      if (n == '0) n = NUM_CH_BITS'(1);
      if (n > NUM_CH_BITS'(MAX_SLOTS)) n = NUM_CH_BITS'(MAX_SLOTS);

      slot_inc  = {1'b0, slot_ff} + NUM_CH_BITS'(1);
      wrap      = (slot_inc >= n);
      slot_next = wrap ? '0 : slot_inc[SLOT_BITS-1:0];

      list = {cfg.channel_list_high, cfg.channel_list_low};

      result.slot          = slot_ff;
      result.value         = VALUE_BITS'(acc_sum >> shift);
      result.next_channel  = list[slot_next*CHAN_BITS +: CHAN_BITS];
      result.scan_complete = wrap;

      acc_in   = acc_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      if (step) begin
         if (hit) begin
            acc_in   = '0;
            count_in = '0;
            slot_in  = slot_next;
         end else begin
            acc_in   = acc_sum;
            count_in = count_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
         slot_ff  <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
      end
   end

   assign slot_index = slot_ff;

endmodule

// ===== rtl/oversampling_adc_channel_scan.sv =====
// Oversampling converter channel scan.
//
// req carries one converter sample per transaction; rsp carries one averaged
// result (slot, value, next_channel, scan_complete) for every 2^oversample_log2
// samples (exponent capped at 16). The csr_ port writes the five scan registers, one per
// cycle, with no read-back; write them only while no sample is in flight.
//
// A sample is held in the input register, where the add into the
// slot accumulator, the count compare and the result shift are done; a
// finished result is then registered in the output register that drives
// rsp. One sample is taken every cycle while no result waits on a stalled
// rsp, set by the single accumulate-and-compare stage.
//
// When rsp stalls, the finished result holds in the output register and at
// most one more sample is taken into the input register; req.ready then drops until
// rsp is taken. Reset clears the accumulator, sample count and slot to zero
// and loads num_channels 1, oversample_log2 1, extra_bits 0, empty lists.
module oversampling_adc_channel_scan #(
   parameter int MAX_SLOTS   = 16,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   ovs_req_if.sink                             req,
   ovs_rsp_if.source                           rsp,
   input  logic                                csr_wr_en,
   input  logic [ovs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ovs_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import ovs_pkg::*;

   ovs_cfg_type             cfg;
   ovs_result_type          result;
   ovs_result_type          rsp_data_ff;
   logic                    hit;
   logic [SLOT_BITS-1:0]    slot_index;

   logic                    in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0]  in_sample_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    advance, fire;

   ovs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ovs_core #(
      .MAX_SLOTS   (MAX_SLOTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (fire),
      .sample     (in_sample_ff),
      .hit        (hit),
      .result     (result),
      .slot_index (slot_index)
   );

   always_comb begin
      advance      = !rsp_valid_ff || rsp.ready;
      fire         = in_valid_ff && advance;
      req.ready    = !in_valid_ff || advance;
      in_valid_in  = req.ready ? req.valid : in_valid_ff;
      rsp_valid_in = advance ? (in_valid_ff && hit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_sample_ff <= req.sample;
      end
      // load only on a transaction that closes a slot
      if (fire && hit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.slot          = rsp_data_ff.slot;
   assign rsp.value         = rsp_data_ff.value;
   assign rsp.next_channel  = rsp_data_ff.next_channel;
   assign rsp.scan_complete = rsp_data_ff.scan_complete;

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a sample in the input register");

   a_wrap_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.scan_complete) |-> (slot_index == '0))
      else $error("scan wrap reported but slot did not return to zero");

   a_stall_only: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp_valid_ff && !rsp.ready && in_valid_ff))
      else $error("input held off without an output stall");

endmodule
